// ===== hw/rtl/sbct_pkg.sv =====
// Shared types and constants for the swept box collision time block.
// Depends on nothing; every other RTL file refers to it by scoped names.
`default_nettype none

package sbct_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int HALF_WIDTH  = 12;
  localparam int MOVE_WIDTH  = 8;
  localparam int OUT_WIDTH   = 10;
  localparam int TIME_SCALE  = 1000;

  // |edge - pos| fits in 17 bits; keep one spare for the sign work.
  localparam int NUM_WIDTH   = COORD_WIDTH + 2;
  localparam int SUM_WIDTH   = HALF_WIDTH + 1;
  // Quotient bits kept; anything >= 2**QBITS saturates (beyond the frame).
  localparam int QBITS       = 10;
  localparam int PROD_WIDTH  = NUM_WIDTH + QBITS - 1;
  localparam int REM_WIDTH   = MOVE_WIDTH + QBITS;
  localparam int TIME_WIDTH  = QBITS + 2;
  localparam int DIV_STAGES  = QBITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);
  localparam int QIDX_WIDTH  = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] mover_x;
    logic signed [COORD_WIDTH-1:0] mover_y;
    logic        [HALF_WIDTH-1:0]  mover_half;
    logic signed [COORD_WIDTH-1:0] target_x;
    logic signed [COORD_WIDTH-1:0] target_y;
    logic        [HALF_WIDTH-1:0]  target_half;
    logic signed [MOVE_WIDTH-1:0]  move_x;
    logic signed [MOVE_WIDTH-1:0]  move_y;
  } req_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] contact_time;
    logic                 hit;
  } rsp_t;

  // One division in flight: partial remainder, quotient so far, sign, overflow.
  typedef struct packed {
    logic [REM_WIDTH-1:0] rem;
    logic [QBITS-1:0]     q;
    logic                 neg;
    logic                 sat;
  } lane_t;

  typedef struct packed {
    lane_t                 edge_lo;
    lane_t                 edge_hi;
    logic [MOVE_WIDTH-1:0] dv;
    logic                  zero;
    logic                  overlap;
  } axis_t;

  typedef struct packed {
    axis_t ax;
    axis_t ay;
  } work_t;

  typedef logic signed [TIME_WIDTH-1:0] time_t;

  typedef struct packed {
    time_t lo;
    time_t hi;
  } span_t;

  typedef struct packed {
    span_t sx;
    span_t sy;
  } pair_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sbct_front.sv =====
// Front end: relative geometry, scaled slab numerators and divider setup.
// Depends on sbct_pkg.
`default_nettype none

module sbct_front (
  input  wire sbct_pkg::req_t  req_data,
  output sbct_pkg::work_t      work
);

  function automatic sbct_pkg::lane_t mk_lane(
    input logic signed [sbct_pkg::NUM_WIDTH-1:0] n,
    input logic [sbct_pkg::MOVE_WIDTH-1:0]       dv,
    input logic                                  vel_neg
  );
    sbct_pkg::lane_t                     l;
    logic [sbct_pkg::NUM_WIDTH-1:0]      mag;
    logic [sbct_pkg::PROD_WIDTH-1:0]     prod;
    mag  = n[sbct_pkg::NUM_WIDTH-1] ? sbct_pkg::NUM_WIDTH'(-n)
                                    : sbct_pkg::NUM_WIDTH'(n);
    prod = sbct_pkg::PROD_WIDTH'(mag) * sbct_pkg::PROD_WIDTH'(sbct_pkg::TIME_SCALE);
    l.sat = prod >= (sbct_pkg::PROD_WIDTH'(dv) << sbct_pkg::QBITS);
    l.rem = prod[sbct_pkg::REM_WIDTH-1:0];
    l.q   = '0;
    l.neg = n[sbct_pkg::NUM_WIDTH-1] ^ vel_neg;
    return l;
  endfunction

  function automatic sbct_pkg::axis_t mk_axis(
    input logic signed [sbct_pkg::COORD_WIDTH-1:0] tgt,
    input logic signed [sbct_pkg::COORD_WIDTH-1:0] mov,
    input logic [sbct_pkg::SUM_WIDTH-1:0]          s,
    input logic signed [sbct_pkg::MOVE_WIDTH-1:0]  d
  );
    sbct_pkg::axis_t                          a;
    logic signed [sbct_pkg::NUM_WIDTH-1:0]    pos;
    logic signed [sbct_pkg::NUM_WIDTH-1:0]    ss;
    logic                                     vel_neg;
    pos = sbct_pkg::NUM_WIDTH'(tgt) - sbct_pkg::NUM_WIDTH'(mov);
    ss  = $signed(sbct_pkg::NUM_WIDTH'(s));
    // velocity is -d, so it is negative when d is positive
    vel_neg  = !d[sbct_pkg::MOVE_WIDTH-1] && (d != '0);
    a.dv     = d[sbct_pkg::MOVE_WIDTH-1] ? sbct_pkg::MOVE_WIDTH'(-d)
                                         : sbct_pkg::MOVE_WIDTH'(d);
    a.zero   = (d == '0);
    a.overlap = (-ss < pos) && (pos < ss);
    a.edge_lo = mk_lane(-ss - pos, a.dv, vel_neg);
    a.edge_hi = mk_lane(ss - pos, a.dv, vel_neg);
    return a;
  endfunction

  logic [sbct_pkg::SUM_WIDTH-1:0] sum_half;

  assign sum_half = sbct_pkg::SUM_WIDTH'(req_data.mover_half)
                  + sbct_pkg::SUM_WIDTH'(req_data.target_half);

  assign work.ax = mk_axis(req_data.target_x, req_data.mover_x, sum_half, req_data.move_x);
  assign work.ay = mk_axis(req_data.target_y, req_data.mover_y, sum_half, req_data.move_y);

endmodule

`default_nettype wire

// ===== hw/rtl/sbct_queue.sv =====
// Short shift queue between front and back; head always in slot 0.
// Depends on sbct_pkg.
`default_nettype none

module sbct_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  wire sbct_pkg::work_t push_data,
  input  wire                  pop,
  output logic                 full,
  output logic                 nonempty,
  output sbct_pkg::work_t      head
);

  sbct_pkg::work_t                   slot [sbct_pkg::QUEUE_DEPTH];
  logic [sbct_pkg::QCNT_WIDTH-1:0]   count;
  logic [sbct_pkg::QCNT_WIDTH-1:0]   count_next;
  logic [sbct_pkg::QIDX_WIDTH-1:0]   widx;

  assign full     = (count == sbct_pkg::QCNT_WIDTH'(sbct_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slot[0];
  assign widx     = sbct_pkg::QIDX_WIDTH'(count - sbct_pkg::QCNT_WIDTH'(pop));

  always_comb begin
    count_next = count + sbct_pkg::QCNT_WIDTH'(push) - sbct_pkg::QCNT_WIDTH'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < sbct_pkg::QUEUE_DEPTH; i++) begin
      if (push && (widx == sbct_pkg::QIDX_WIDTH'(i))) begin
        slot[i] <= push_data;
      end else if (pop && (i < sbct_pkg::QUEUE_DEPTH - 1)) begin
        slot[i] <= slot[(i + 1) % sbct_pkg::QUEUE_DEPTH];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sbct_back.sv =====
// Back end: four restoring dividers as a bit-per-stage pipeline, slab sort,
// candidate select and the output register. Depends on sbct_pkg.
`default_nettype none

module sbct_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  src_valid,
  input  wire sbct_pkg::work_t src_data,
  output logic                 src_pop,
  output logic                 rsp_valid,
  input  wire                  rsp_stall,
  output sbct_pkg::rsp_t       rsp_data
);

  function automatic sbct_pkg::lane_t lane_step(
    input sbct_pkg::lane_t                 l,
    input logic [sbct_pkg::MOVE_WIDTH-1:0] dv,
    input int                              b
  );
    sbct_pkg::lane_t                r;
    logic [sbct_pkg::REM_WIDTH-1:0] d;
    r = l;
    d = sbct_pkg::REM_WIDTH'(dv) << b;
    if (l.rem >= d) begin
      r.rem = l.rem - d;
      r.q   = l.q | (sbct_pkg::QBITS'(1) << b);
    end
    return r;
  endfunction

  function automatic sbct_pkg::axis_t axis_step(input sbct_pkg::axis_t a, input int b);
    sbct_pkg::axis_t r;
    r = a;
    r.edge_lo = lane_step(a.edge_lo, a.dv, b);
    r.edge_hi = lane_step(a.edge_hi, a.dv, b);
    return r;
  endfunction

  function automatic sbct_pkg::time_t lane_time(input sbct_pkg::lane_t l);
    logic [sbct_pkg::QBITS-1:0] mag;
    sbct_pkg::time_t            t;
    mag = l.sat ? '1 : l.q;
    t   = $signed(sbct_pkg::TIME_WIDTH'(mag));
    return l.neg ? -t : t;
  endfunction

  function automatic sbct_pkg::span_t axis_span(input sbct_pkg::axis_t a);
    sbct_pkg::span_t sp;
    sbct_pkg::time_t t0;
    sbct_pkg::time_t t1;
    t0 = lane_time(a.edge_lo);
    t1 = lane_time(a.edge_hi);
    if (a.zero) begin
      sp.lo = a.overlap ? -sbct_pkg::TIME_WIDTH'(sbct_pkg::TIME_SCALE)
                        : sbct_pkg::TIME_WIDTH'(sbct_pkg::TIME_SCALE);
      sp.hi = sbct_pkg::TIME_WIDTH'(sbct_pkg::TIME_SCALE);
    end else if (t0 > t1) begin
      sp.lo = t1;
      sp.hi = t0;
    end else begin
      sp.lo = t0;
      sp.hi = t1;
    end
    return sp;
  endfunction

  function automatic logic counts(
    input sbct_pkg::time_t c,
    input sbct_pkg::span_t o,
    input sbct_pkg::time_t best
  );
    return (c >= 0) && (c < sbct_pkg::TIME_WIDTH'(sbct_pkg::TIME_SCALE))
        && (o.lo <= c) && (c <= o.hi) && (c < best);
  endfunction

  logic            adv;
  logic            stage_v [sbct_pkg::DIV_STAGES + 1];
  sbct_pkg::work_t stage_d [sbct_pkg::DIV_STAGES + 1];
  logic            sort_v;
  sbct_pkg::pair_t sort_d;
  sbct_pkg::time_t best;

  // Whole pipeline moves when the output register is free or being taken.
  assign adv     = !rsp_valid || !rsp_stall;
  assign src_pop = adv && src_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v[0] <= 1'b0;
    end else if (adv) begin
      stage_v[0] <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage_d[0] <= src_data;
    end
  end

  for (genvar k = 0; k < sbct_pkg::DIV_STAGES; k++) begin : g_div
    localparam int QB = sbct_pkg::DIV_STAGES - 1 - k;

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_v[k+1] <= 1'b0;
      end else if (adv) begin
        stage_v[k+1] <= stage_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stage_d[k+1].ax <= axis_step(stage_d[k].ax, QB);
        stage_d[k+1].ay <= axis_step(stage_d[k].ay, QB);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_v <= 1'b0;
    end else if (adv) begin
      sort_v <= stage_v[sbct_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sort_d.sx <= axis_span(stage_d[sbct_pkg::DIV_STAGES].ax);
      sort_d.sy <= axis_span(stage_d[sbct_pkg::DIV_STAGES].ay);
    end
  end

  // Earliest of the four slab edges that lies inside the other axis' span.
  always_comb begin
    best = sbct_pkg::TIME_WIDTH'(sbct_pkg::TIME_SCALE);
    if (counts(sort_d.sx.lo, sort_d.sy, best)) best = sort_d.sx.lo;
    if (counts(sort_d.sx.hi, sort_d.sy, best)) best = sort_d.sx.hi;
    if (counts(sort_d.sy.lo, sort_d.sx, best)) best = sort_d.sy.lo;
    if (counts(sort_d.sy.hi, sort_d.sx, best)) best = sort_d.sy.hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= sort_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp_data.contact_time <= best[sbct_pkg::OUT_WIDTH-1:0];
      rsp_data.hit          <= (best < sbct_pkg::TIME_WIDTH'(sbct_pkg::TIME_SCALE));
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/swept_box_collision_time.sv =====
// Swept square collision time, top level: front, queue and back end.
// Depends on sbct_pkg, sbct_front, sbct_queue and sbct_back.
//
// Usage:
//   req channel (req_valid/req_stall/req_data) takes one query per beat: a
//   moving square, its displacement for the frame and a fixed square.
//   rsp channel (rsp_valid/rsp_stall/rsp_data) returns one beat per query,
//   in order: contact_time in thousandths of the frame (1000 = no contact)
//   and hit.
// Throughput: one beat per cycle while rsp_stall is low. The four
//   slab divisions run as restoring dividers, one quotient bit per pipeline stage.
// Path: an accepted req beat reaches rsp_valid through the queue entry,
//   11 divider registers, sort stage and output register.
// Stall: a stalled rsp beat freezes the whole back-end pipeline; the
//   4-entry queue keeps taking req beats until full, then req_stall rises.
// Reset: synchronous; clears queue count and all stage valids. No
//   state survives between queries.
// Quotients of 1024 or more saturate; they lie past the frame and never
//   change the answer.
`default_nettype none

module swept_box_collision_time (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_stall,
  input  wire sbct_pkg::req_t req_data,
  output logic                rsp_valid,
  input  wire                 rsp_stall,
  output sbct_pkg::rsp_t      rsp_data
);

  sbct_pkg::work_t front_work;
  sbct_pkg::work_t q_head;
  logic            q_full;
  logic            q_nonempty;
  logic            q_pop;
  logic            q_push;

  assign req_stall = q_full;
  assign q_push    = req_valid && !q_full;

  sbct_front u_front (
    .req_data (req_data),
    .work     (front_work)
  );

  sbct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (front_work),
    .pop       (q_pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  sbct_back u_back (
    .clk       (clk),
    .rst       (rst),
    .src_valid (q_nonempty),
    .src_data  (q_head),
    .src_pop   (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/sbct_checker.sv =====
// Port-level checks for swept_box_collision_time, attached by bind.
// Depends on sbct_pkg.
`default_nettype none

module sbct_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 rsp_valid,
  input wire                 rsp_stall,
  input wire sbct_pkg::rsp_t rsp_data
);

  // A stalled result beat holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("rsp beat changed while stalled");

  // hit agrees with contact_time, which never exceeds the frame scale.
  a_hit_match: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.hit == (rsp_data.contact_time != 10'd1000))
                  && (rsp_data.contact_time <= 10'd1000))
    else $error("hit and contact_time disagree");

  // Nothing comes out right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp_valid after reset");

endmodule

bind swept_box_collision_time sbct_checker u_sbct_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_data  (rsp_data)
);

`default_nettype wire
